// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/utf8d_pkg.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder package
// Field widths and encoding constants shared by the channels and the decoder.
// ---------------------------------------------------------------------------
package utf8d_pkg;

    localparam int BYTE_WIDTH    = 8;
    localparam int CP_WIDTH      = 21;
    localparam int OUT_OFF_WIDTH = 32;

    localparam logic [CP_WIDTH-1:0] REPL_CHAR    = 21'h00FFFD;
    localparam logic [CP_WIDTH-1:0] MAX_SCALAR   = 21'h10FFFF;
    localparam logic [CP_WIDTH-1:0] SURR_LOW     = 21'h00D800;
    localparam logic [CP_WIDTH-1:0] SURR_HIGH    = 21'h00DFFF;
    localparam logic [CP_WIDTH-1:0] MIN_TWO_BYTE = 21'h000080;
    localparam logic [CP_WIDTH-1:0] MIN_THREE    = 21'h000800;
    localparam logic [CP_WIDTH-1:0] MIN_FOUR     = 21'h010000;

    // Sequence lengths; LEN_NONE means nothing is pending.
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

endpackage

// ===== sv/utf8d_in_if.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder byte channel
// Valid/ready channel carrying one raw byte and its end-of-string flag.
// ---------------------------------------------------------------------------
interface utf8d_in_if
    import utf8d_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [BYTE_WIDTH-1:0] data_byte;
    logic                  end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

// ===== sv/utf8d_out_if.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder scalar channel
// Valid/ready channel carrying one decoded scalar and its byte offset.
// ---------------------------------------------------------------------------
interface utf8d_out_if
    import utf8d_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CP_WIDTH-1:0]      code_point;
    logic [OUT_OFF_WIDTH-1:0] start_offset;
    logic                     replaced;
    logic                     last_of_run;

    modport source (output valid, output code_point, output start_offset,
                    output replaced, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input start_offset,
                    input replaced, input last_of_run, output ready);
endinterface

// ===== sv/utf8_stream_decoder.sv =====
// ---------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream into Unicode scalars with U+FFFD for malformed input.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                                           | item
//  ---------+-----+---------------------------------------------------+------------
//  octets   | in  | data_byte[7:0], end_of_string                     | one byte
//  scalars  | out | code_point[20:0], start_offset[31:0], replaced,   | one scalar
//           |     | last_of_run                                       |
//
//  A byte passes an input register, then a decode loads a burst register
//  with zero to four scalars. With the output ready, the burst shifts out
//  one scalar per cycle and well-formed text sustains one byte per cycle;
//  a byte yielding a multi-scalar burst holds the input until the burst's
//  last scalar is taken. Reset clears pending sequence, offset counter and
//  both stages. Output stalls back up through the burst and input registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_stream_decoder
    import utf8d_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    utf8d_in_if.sink     octets,
    utf8d_out_if.source  scalars
);

    // Input register
    logic                    in_valid_reg;
    logic [BYTE_WIDTH-1:0]   in_byte_reg;
    logic                    in_eos_reg;

    // Decoder state
    logic [2:0]              need_reg, need_next;
    logic [1:0]              held_reg, held_next;
    logic [CP_WIDTH-1:0]     partial_reg, partial_next;
    logic [OFFSET_WIDTH-1:0] seq_start_reg, seq_start_next;
    logic [OFFSET_WIDTH-1:0] counter_reg, counter_next;

    // Burst register
    logic                    bst_valid_reg;
    logic [OFFSET_WIDTH-1:0] bst_base_reg;
    logic [2:0]              bst_count_reg;
    logic [1:0]              bst_idx_reg;
    logic [CP_WIDTH-1:0]     bst_cp_reg;
    logic                    bst_rep_reg;

    // Decode results
    logic [OFFSET_WIDTH-1:0] dec_base;
    logic [2:0]              dec_count;
    logic [CP_WIDTH-1:0]     dec_cp;
    logic                    dec_rep;

    logic                    out_fire;
    logic                    bst_last;
    logic                    burst_free;
    logic                    decode_fire;
    logic [2:0]              idx_ext;

    logic                    pending;
    logic                    is_cont;
    logic [CP_WIDTH-1:0]     acc;
    logic [2:0]              held_inc;
    logic [2:0]              pre;
    logic                    scalar_ok;

    logic [OFFSET_WIDTH-1:0]               off_cur;
    logic [OFFSET_WIDTH+OUT_OFF_WIDTH-1:0] off_ext;

    // -----------------------------------------------------------------------
    // Handshake
    // -----------------------------------------------------------------------
    assign idx_ext     = {1'b0, bst_idx_reg};
    assign bst_last    = (idx_ext + 3'd1) == bst_count_reg;
    assign out_fire    = scalars.valid && scalars.ready;
    assign burst_free  = !bst_valid_reg || (out_fire && bst_last);
    assign decode_fire = in_valid_reg && burst_free;
    assign octets.ready = !in_valid_reg || decode_fire;

    // -----------------------------------------------------------------------
    // Decode
    // -----------------------------------------------------------------------
    assign pending  = need_reg != LEN_NONE;
    assign is_cont  = in_byte_reg[7:6] == 2'b10;
    assign acc      = {partial_reg[CP_WIDTH-7:0], in_byte_reg[5:0]};
    assign held_inc = {1'b0, held_reg} + 3'd1;
    assign pre      = pending ? {1'b0, held_reg} : LEN_NONE;

    always_comb
    begin
        unique case (need_reg)
            LEN_TWO:   scalar_ok = acc >= MIN_TWO_BYTE;
            LEN_THREE: scalar_ok = (acc >= MIN_THREE) && !((acc >= SURR_LOW) && (acc <= SURR_HIGH));
            LEN_FOUR:  scalar_ok = (acc >= MIN_FOUR) && (acc <= MAX_SCALAR);
            default:   scalar_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        need_next      = need_reg;
        held_next      = held_reg;
        partial_next   = partial_reg;
        seq_start_next = seq_start_reg;
        counter_next   = in_eos_reg ? '0 : counter_reg + OFFSET_WIDTH'(1);
        dec_base       = seq_start_reg;
        dec_count      = LEN_NONE;
        dec_cp         = REPL_CHAR;
        dec_rep        = 1'b1;

        if (pending && is_cont)
        begin
            if (held_inc == need_reg)
            begin
                need_next    = LEN_NONE;
                held_next    = 2'd0;
                partial_next = '0;
                if (scalar_ok)
                begin
                    dec_count = LEN_ONE;
                    dec_cp    = acc;
                    dec_rep   = 1'b0;
                end
                else
                begin
                    dec_count = need_reg;
                end
            end
            else if (in_eos_reg)
            begin
                // truncated at end of string: flush every held byte and this one
                dec_count    = held_inc;
                need_next    = LEN_NONE;
                held_next    = 2'd0;
                partial_next = '0;
            end
            else
            begin
                held_next    = held_inc[1:0];
                partial_next = acc;
            end
        end
        else
        begin
            // flush held bytes (if any), then take this byte as a lead;
            // its offset follows the held run directly
            if (!pending)
            begin
                dec_base = counter_reg;
            end
            need_next    = LEN_NONE;
            held_next    = 2'd0;
            partial_next = '0;
            if (!in_byte_reg[7])
            begin
                dec_count = pre + 3'd1;
                dec_cp    = {13'd0, in_byte_reg};
                dec_rep   = 1'b0;
            end
            else if (in_byte_reg[7:5] == 3'b110 || in_byte_reg[7:4] == 4'b1110 ||
                     in_byte_reg[7:3] == 5'b11110)
            begin
                if (in_eos_reg)
                begin
                    dec_count = pre + 3'd1;
                end
                else
                begin
                    dec_count      = pre;
                    held_next      = 2'd1;
                    seq_start_next = counter_reg;
                    if (in_byte_reg[7:5] == 3'b110)
                    begin
                        need_next    = LEN_TWO;
                        partial_next = {16'd0, in_byte_reg[4:0]};
                    end
                    else if (in_byte_reg[7:4] == 4'b1110)
                    begin
                        need_next    = LEN_THREE;
                        partial_next = {17'd0, in_byte_reg[3:0]};
                    end
                    else
                    begin
                        need_next    = LEN_FOUR;
                        partial_next = {18'd0, in_byte_reg[2:0]};
                    end
                end
            end
            else
            begin
                dec_count = pre + 3'd1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (octets.ready)
        begin
            in_valid_reg <= octets.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (octets.ready && octets.valid)
        begin
            in_byte_reg <= octets.data_byte;
            in_eos_reg  <= octets.end_of_string;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg      <= LEN_NONE;
            held_reg      <= 2'd0;
            partial_reg   <= '0;
            seq_start_reg <= '0;
            counter_reg   <= '0;
        end
        else if (decode_fire)
        begin
            need_reg      <= need_next;
            held_reg      <= held_next;
            partial_reg   <= partial_next;
            seq_start_reg <= seq_start_next;
            counter_reg   <= counter_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bst_valid_reg <= 1'b0;
            bst_count_reg <= LEN_NONE;
            bst_idx_reg   <= 2'd0;
        end
        else if (decode_fire)
        begin
            bst_valid_reg <= dec_count != LEN_NONE;
            bst_count_reg <= dec_count;
            bst_idx_reg   <= 2'd0;
        end
        else if (out_fire)
        begin
            if (bst_last)
            begin
                bst_valid_reg <= 1'b0;
            end
            else
            begin
                bst_idx_reg <= bst_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (decode_fire)
        begin
            bst_base_reg <= dec_base;
            bst_cp_reg   <= dec_cp;
            bst_rep_reg  <= dec_rep;
        end
    end

    // -----------------------------------------------------------------------
    // Output: replacements first, the tail scalar last
    // -----------------------------------------------------------------------
    assign off_cur = bst_base_reg + OFFSET_WIDTH'(bst_idx_reg);
    assign off_ext = {{OUT_OFF_WIDTH{1'b0}}, off_cur};

    assign scalars.valid        = bst_valid_reg;
    assign scalars.code_point   = bst_last ? bst_cp_reg : REPL_CHAR;
    assign scalars.replaced     = bst_last ? bst_rep_reg : 1'b1;
    assign scalars.last_of_run  = bst_last;
    assign scalars.start_offset = off_ext[OUT_OFF_WIDTH-1:0];

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `ASSERT_IMPLY(a_burst_count, bst_valid_reg, (bst_count_reg != LEN_NONE) && (bst_count_reg <= LEN_FOUR), "burst count out of range")
    `ASSERT_IMPLY(a_burst_idx, bst_valid_reg, idx_ext < bst_count_reg, "burst index past count")
    `ASSERT_IMPLY(a_held_range, need_reg != LEN_NONE, (held_reg != 2'd0) && ({1'b0, held_reg} < need_reg), "held count inconsistent")
    `ASSERT_IMPLY(a_idle_clear, need_reg == LEN_NONE, held_reg == 2'd0, "bytes held with nothing pending")
    `ASSERT_NEXT(a_burst_load, decode_fire && (dec_count != LEN_NONE), bst_valid_reg && (bst_idx_reg == 2'd0), "burst not loaded")

endmodule
